// ===== design/whtc_pkg.sv =====
// Shared types and constants for the water heater thermostat controller.
// Used by whtc_cfg, whtc_ctrl and water_heater_thermostat_control.
package whtc_pkg;

  // event codes carried in the input tuser
  localparam logic [2:0] EV_TICK    = 3'd0;
  localparam logic [2:0] EV_POWER   = 3'd1;
  localparam logic [2:0] EV_DOWN    = 3'd2;
  localparam logic [2:0] EV_UP      = 3'd3;
  localparam logic [2:0] EV_TEMP    = 3'd4;
  localparam logic [2:0] EV_RESTORE = 3'd5;

  // run modes
  localparam logic [1:0] RUN_OFF = 2'd0;
  localparam logic [1:0] RUN_ON  = 2'd1;
  localparam logic [1:0] RUN_SET = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_LOW_LIMIT   = 3'd0;
  localparam logic [2:0] REG_HIGH_LIMIT  = 3'd1;
  localparam logic [2:0] REG_STEP_SIZE   = 3'd2;
  localparam logic [2:0] REG_BAND        = 3'd3;
  localparam logic [2:0] REG_TIMEOUT     = 3'd4;
  localparam logic [2:0] REG_DEFAULT_SP  = 3'd5;

  // reset values
  localparam logic [7:0] LOW_LIMIT_RST  = 8'd35;
  localparam logic [7:0] HIGH_LIMIT_RST = 8'd75;
  localparam logic [7:0] STEP_SIZE_RST  = 8'd5;
  localparam logic [7:0] BAND_RST       = 8'd5;
  localparam logic [7:0] TIMEOUT_RST    = 8'd5;
  localparam logic [7:0] DEFAULT_SP_RST = 8'd60;
  localparam logic [7:0] SETPOINT_RST   = 8'd60;

  // stored setpoint byte that means "nothing saved"
  localparam logic [7:0] SP_EMPTY = 8'hff;

  typedef struct packed {
    logic [7:0] low_limit;
    logic [7:0] high_limit;
    logic [7:0] step_size;
    logic [7:0] band;
    logic [7:0] timeout_seconds;
    logic [7:0] default_setpoint;
  } cfg_t;

  typedef struct packed {
    logic [1:0] run_state;
    logic       heater_pin;
    logic       fan_pin;
    logic       hot_indicator;
    logic       display_on;
    logic [9:0] display_value;
    logic       save_strobe;
    logic [7:0] save_value;
  } result_t;

endpackage

// ===== design/water_heater_thermostat_control.sv =====
// Top level of the water heater hysteresis thermostat controller.
// Depends on whtc_pkg, whtc_cfg and whtc_ctrl.
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tuser: event, tdata: value
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata: one result beat
//   cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// Each event beat yields exactly one result beat, via the input register and
// the result register. Sustained rate is one beat per cycle while m_axis is
// ready; the event logic and thermostat state sit between the two registers.
// rst (synchronous) restores the configuration defaults, the off mode and a
// setpoint of 60. A stall on m_axis backs up through the input register; the
// input register still takes a beat while a result waits for its taker.
module water_heater_thermostat_control #(
  parameter int TEMP_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] value, [15:10] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] mode (event code)

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [1:0] run_state, [2] heater_pin, [3] fan_pin,
                                      // [4] hot_indicator, [5] display_on,
                                      // [15:6] display_value, [16] save_strobe,
                                      // [24:17] save_value, [31:25] zero

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  whtc_pkg::cfg_t    cfg;
  whtc_pkg::result_t step_result;
  whtc_pkg::result_t out_result;

  // input register
  logic       in_valid;
  logic [2:0] in_mode;
  logic [9:0] in_value;

  logic out_valid;
  logic advance;

  // Move the held event into the result register whenever that register is
  // empty or is being drained this cycle.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Registers always writable; user must change configuration only while idle, unenforced.
  assign cfg_ready = 1'b1;

  whtc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  whtc_ctrl #(
    .TEMP_BITS (TEMP_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .ev     (in_mode),
    .value  (in_value),
    .cfg    (cfg),
    .result (step_result)
  );

  // capture an event beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode  <= s_axis_tuser;
      in_value <= s_axis_tdata[9:0];
    end
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0,
                          out_result.save_value,
                          out_result.save_strobe,
                          out_result.display_value,
                          out_result.display_on,
                          out_result.hot_indicator,
                          out_result.fan_pin,
                          out_result.heater_pin,
                          out_result.run_state};

endmodule

// ===== design/whtc_cfg.sv =====
// Configuration register bank for the thermostat controller.
// Depends on whtc_pkg (cfg_t, register indexes, reset values).
module whtc_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [7:0]          wr_data,
  output whtc_pkg::cfg_t      cfg
);

  whtc_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.low_limit        <= whtc_pkg::LOW_LIMIT_RST;
      regs.high_limit       <= whtc_pkg::HIGH_LIMIT_RST;
      regs.step_size        <= whtc_pkg::STEP_SIZE_RST;
      regs.band             <= whtc_pkg::BAND_RST;
      regs.timeout_seconds  <= whtc_pkg::TIMEOUT_RST;
      regs.default_setpoint <= whtc_pkg::DEFAULT_SP_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        whtc_pkg::REG_LOW_LIMIT:  regs.low_limit        <= wr_data;
        whtc_pkg::REG_HIGH_LIMIT: regs.high_limit       <= wr_data;
        whtc_pkg::REG_STEP_SIZE:  regs.step_size        <= wr_data;
        whtc_pkg::REG_BAND:       regs.band             <= wr_data;
        whtc_pkg::REG_TIMEOUT:    regs.timeout_seconds  <= wr_data;
        whtc_pkg::REG_DEFAULT_SP: regs.default_setpoint <= wr_data;
        default: ;  // drop writes beyond the bank
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== design/whtc_ctrl.sv =====
// Thermostat state and per-event update logic.
// Depends on whtc_pkg (event and mode codes, cfg_t, result_t).
module whtc_ctrl #(
  parameter int TEMP_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [2:0]          ev,
  input  logic [9:0]          value,
  input  whtc_pkg::cfg_t      cfg,
  output whtc_pkg::result_t   result
);

  localparam int CW = ((TEMP_BITS > 8) ? TEMP_BITS : 8) + 1;

  logic [1:0]           run_mode, run_mode_next;
  logic [7:0]           setpoint, setpoint_next;
  logic [7:0]           seconds, seconds_next;
  logic [TEMP_BITS-1:0] temperature, temperature_next;
  logic                 heater_level, heater_level_next;
  logic                 fan_level, fan_level_next;
  logic                 hot_flag, hot_flag_next;

  logic [8:0]    up_sum, dn_diff;
  logic [7:0]    up_val, dn_val;
  logic [CW-1:0] t_ext, sp_ext, b_ext;

  // clamped setpoint steps, from the setpoint before this event
  assign up_sum  = {1'b0, setpoint} + {1'b0, cfg.step_size};
  assign dn_diff = {1'b0, setpoint} - {1'b0, cfg.step_size};
  assign up_val  = (up_sum > {1'b0, cfg.high_limit}) ? cfg.high_limit : up_sum[7:0];
  assign dn_val  = (dn_diff[8] || (dn_diff[7:0] < cfg.low_limit)) ? cfg.low_limit
                                                                  : dn_diff[7:0];

  assign t_ext  = CW'(temperature_next);
  assign sp_ext = CW'(setpoint_next);
  assign b_ext  = CW'(cfg.band);

  always_comb begin
    run_mode_next     = run_mode;
    setpoint_next     = setpoint;
    seconds_next      = seconds;
    temperature_next  = temperature;
    heater_level_next = heater_level;
    fan_level_next    = fan_level;
    hot_flag_next     = hot_flag;
    result            = '0;

    unique case (ev) inside
      whtc_pkg::EV_TICK: seconds_next = seconds + 8'd1;
      whtc_pkg::EV_POWER: begin
        run_mode_next = (run_mode == whtc_pkg::RUN_OFF) ? whtc_pkg::RUN_ON
                                                        : whtc_pkg::RUN_OFF;
      end
      whtc_pkg::EV_DOWN, whtc_pkg::EV_UP: begin
        if (run_mode == whtc_pkg::RUN_ON) begin
          run_mode_next = whtc_pkg::RUN_SET;
          seconds_next  = 8'd0;
        end else if (run_mode == whtc_pkg::RUN_SET) begin
          setpoint_next = (ev == whtc_pkg::EV_UP) ? up_val : dn_val;
          seconds_next  = 8'd0;
        end
      end
      whtc_pkg::EV_TEMP: temperature_next = TEMP_BITS'(value);
      whtc_pkg::EV_RESTORE: begin
        setpoint_next = (value[7:0] == whtc_pkg::SP_EMPTY) ? cfg.default_setpoint
                                                           : value[7:0];
      end
      default: ;
    endcase

    // set-mode timeout: offer the setpoint for saving, fall back to on
    if ((run_mode_next == whtc_pkg::RUN_SET) && (seconds_next == cfg.timeout_seconds)) begin
      result.save_strobe = 1'b1;
      result.save_value  = setpoint_next;
      seconds_next       = 8'd0;
      run_mode_next      = whtc_pkg::RUN_ON;
    end

    if (run_mode_next == whtc_pkg::RUN_OFF) begin
      heater_level_next = 1'b0;
      fan_level_next    = 1'b0;
    end else if (run_mode_next == whtc_pkg::RUN_ON) begin
      if ((t_ext + b_ext) <= sp_ext) begin
        heater_level_next = 1'b0;
        fan_level_next    = 1'b1;
      end else if (t_ext >= (sp_ext + b_ext)) begin
        heater_level_next = 1'b1;
        fan_level_next    = 1'b0;
        hot_flag_next     = 1'b1;
      end
      result.display_on    = 1'b1;
      result.display_value = 10'(temperature_next);
    end else begin
      result.display_on    = ~seconds_next[0];
      result.display_value = 10'(setpoint_next);
    end

    result.run_state     = run_mode_next;
    result.heater_pin    = heater_level_next;
    result.fan_pin       = fan_level_next;
    result.hot_indicator = hot_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode     <= whtc_pkg::RUN_OFF;
      setpoint     <= whtc_pkg::SETPOINT_RST;
      seconds      <= 8'd0;
      temperature  <= '0;
      heater_level <= 1'b0;
      fan_level    <= 1'b0;
      hot_flag     <= 1'b0;
    end else if (fire) begin
      run_mode     <= run_mode_next;
      setpoint     <= setpoint_next;
      seconds      <= seconds_next;
      temperature  <= temperature_next;
      heater_level <= heater_level_next;
      fan_level    <= fan_level_next;
      hot_flag     <= hot_flag_next;
    end
  end

endmodule

// ===== dv/whtc_scoreboard_pkg.sv =====
// Scoreboard for the water heater thermostat bench: predicts one status beat per event.
// Depends on whtc_pkg for event codes, run modes, register indexes and result_t.
package whtc_scoreboard_pkg;
  import whtc_pkg::*;

  // event codes the block treats as no event
  localparam logic [2:0] EV_SPARE6 = 3'd6;
  localparam logic [2:0] EV_SPARE7 = 3'd7;

  class thermostat_scoreboard;
    cfg_t       regs;
    logic [1:0] run_mode;
    logic [7:0] setpoint;
    logic [7:0] seconds;
    logic [9:0] temperature;
    logic       heater;
    logic       fan;
    logic       hot;
    result_t    status_due[$];
    int         events_seen;
    int         statuses_checked;
    int         errors;
    int         saves;

    function new();
      regs.low_limit        = LOW_LIMIT_RST;
      regs.high_limit       = HIGH_LIMIT_RST;
      regs.step_size        = STEP_SIZE_RST;
      regs.band             = BAND_RST;
      regs.timeout_seconds  = TIMEOUT_RST;
      regs.default_setpoint = DEFAULT_SP_RST;
      run_mode    = RUN_OFF;
      setpoint    = SETPOINT_RST;
      seconds     = '0;
      temperature = '0;
      heater      = 1'b0;
      fan         = 1'b0;
      hot         = 1'b0;
    endfunction

    function void write_reg(logic [2:0] index, logic [7:0] data);
      case (index)
        REG_LOW_LIMIT:  regs.low_limit        = data;
        REG_HIGH_LIMIT: regs.high_limit       = data;
        REG_STEP_SIZE:  regs.step_size        = data;
        REG_BAND:       regs.band             = data;
        REG_TIMEOUT:    regs.timeout_seconds  = data;
        REG_DEFAULT_SP: regs.default_setpoint = data;
        default: ;
      endcase
    endfunction

    // apply one accepted event and queue the status beat it must produce
    function void note_event(logic [2:0] code, logic [9:0] value);
      int      sp;
      int      t;
      result_t r;
      r = '0;
      case (code)
        EV_TICK:  seconds = seconds + 8'd1;
        EV_POWER: run_mode = (run_mode == RUN_OFF) ? RUN_ON : RUN_OFF;
        EV_DOWN, EV_UP: begin
          if (run_mode == RUN_ON) begin
            run_mode = RUN_SET;
            seconds  = '0;
          end else if (run_mode == RUN_SET) begin
            sp = int'(setpoint);
            if (code == EV_UP) begin
              sp = sp + int'(regs.step_size);
              if (sp > int'(regs.high_limit)) sp = int'(regs.high_limit);
            end else begin
              sp = sp - int'(regs.step_size);
              if (sp < int'(regs.low_limit)) sp = int'(regs.low_limit);
            end
            setpoint = sp[7:0];
            seconds  = '0;
          end
        end
        EV_TEMP:    temperature = value;
        EV_RESTORE: setpoint = (value[7:0] == SP_EMPTY) ? regs.default_setpoint : value[7:0];
        default: ;
      endcase

      // set-mode timeout: offer the setpoint for saving and fall back to on
      if (run_mode == RUN_SET && seconds == regs.timeout_seconds) begin
        r.save_strobe = 1'b1;
        r.save_value  = setpoint;
        seconds       = '0;
        run_mode      = RUN_ON;
      end

      case (run_mode)
        RUN_OFF: begin
          heater = 1'b0;
          fan    = 1'b0;
        end
        RUN_ON: begin
          t  = int'(temperature);
          sp = int'(setpoint);
          if (t <= sp - int'(regs.band)) begin
            heater = 1'b0;
            fan    = 1'b1;
          end else if (t >= sp + int'(regs.band)) begin
            heater = 1'b1;
            fan    = 1'b0;
            hot    = 1'b1;
          end
          r.display_on    = 1'b1;
          r.display_value = temperature;
        end
        default: begin
          r.display_on    = ~seconds[0];
          r.display_value = {2'b00, setpoint};
        end
      endcase

      r.run_state     = run_mode;
      r.heater_pin    = heater;
      r.fan_pin       = fan;
      r.hot_indicator = hot;
      status_due.push_back(r);
      events_seen++;
    endfunction

    function void check_status(logic [31:0] beat);
      result_t got;
      result_t want;
      string   diff;
      got.run_state     = beat[1:0];
      got.heater_pin    = beat[2];
      got.fan_pin       = beat[3];
      got.hot_indicator = beat[4];
      got.display_on    = beat[5];
      got.display_value = beat[15:6];
      got.save_strobe   = beat[16];
      got.save_value    = beat[24:17];
      if (status_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("status beat %h arrived with no event pending", beat);
        return;
      end
      want = status_due.pop_front();
      statuses_checked++;
      diff = "";
      if (got.run_state !== want.run_state)
        diff = {diff, $sformatf(" run_state %0d/%0d", want.run_state, got.run_state)};
      if (got.heater_pin !== want.heater_pin)
        diff = {diff, $sformatf(" heater %0b/%0b", want.heater_pin, got.heater_pin)};
      if (got.fan_pin !== want.fan_pin)
        diff = {diff, $sformatf(" fan %0b/%0b", want.fan_pin, got.fan_pin)};
      if (got.hot_indicator !== want.hot_indicator)
        diff = {diff, $sformatf(" hot %0b/%0b", want.hot_indicator, got.hot_indicator)};
      if (got.display_on !== want.display_on)
        diff = {diff, $sformatf(" disp_on %0b/%0b", want.display_on, got.display_on)};
      if (got.display_value !== want.display_value)
        diff = {diff, $sformatf(" disp_val %0d/%0d", want.display_value, got.display_value)};
      if (got.save_strobe !== want.save_strobe)
        diff = {diff, $sformatf(" strobe %0b/%0b", want.save_strobe, got.save_strobe)};
      if (got.save_value !== want.save_value)
        diff = {diff, $sformatf(" save_val %0d/%0d", want.save_value, got.save_value)};
      if (beat[31:25] !== 7'd0)
        diff = {diff, $sformatf(" pad 0/%h", beat[31:25])};
      if (diff != "") begin
        errors++;
        if (errors <= 10)
          $display("status %0d mismatch (expected/actual):%s", statuses_checked, diff);
      end
      if (want.save_strobe) saves++;
    endfunction
  endclass

endpackage

// ===== dv/tb.sv =====
// Top-level bench for water_heater_thermostat_control: drives event beats and
// register writes, checks every status beat. Depends on whtc_pkg and whtc_scoreboard_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import whtc_pkg::*;
  import whtc_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 200000;  // far above the slowest legal run
  localparam int HOLD_CYCLES = 300;     // receiver back-pressure stretch
  localparam int DRAIN_CYCLES = 8;      // idle wait after the final drain

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  // idle odds in percent, changed per phase by the main sequence
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_rx = 1'b0;
  int   cycle_count = 0;
  int   events_sent = 0;
  int   settings_run = 0;

  thermostat_scoreboard sb = new();

  water_heater_thermostat_control #(
    .TEMP_BITS(10)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d status beats still due",
               cycle_count, sb.status_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Status side: check the beat taken at this edge, then pick tready for the
  // next one. All signals read here hold their pre-edge values.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
    m_axis_tready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one event beat, with random idle cycles in front, and hold it until
  // accepted. tvalid stays high on return so back-to-back beats need no toggle.
  task automatic send_event(logic [2:0] code, logic [9:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= code;
    s_axis_tdata  <= {6'b0, value};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_event(code, value);
    events_sent++;
  endtask

  // Drop tvalid and wait until every predicted status beat has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk);
  endtask

  // Write all six registers back to back; only call with the block idle.
  task automatic load_config(cfg_t c);
    logic [2:0] idx [6] = '{REG_LOW_LIMIT, REG_HIGH_LIMIT, REG_STEP_SIZE,
                            REG_BAND, REG_TIMEOUT, REG_DEFAULT_SP};
    logic [7:0] vals [6];
    vals = '{c.low_limit, c.high_limit, c.step_size,
             c.band, c.timeout_seconds, c.default_setpoint};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // Random traffic built mostly from realistic bursts: temperature sweeps
  // around the hysteresis band and set-mode sessions that run to the save
  // timeout, with power toggles, restores and plain noise mixed in.
  task automatic run_random(int count);
    int         target;
    int         pick;
    int         lo;
    int         hi;
    int         ticks;
    logic [2:0] code;
    target = events_sent + count;
    while (events_sent < target) begin
      pick = $urandom_range(99);
      if (sb.run_mode == RUN_OFF && pick < 70) begin
        send_event(EV_POWER, 10'($urandom_range(1023)));
      end else if (pick < 35) begin
        // sweep temperatures across both band edges
        lo = int'(sb.setpoint) - int'(sb.regs.band) - 3;
        hi = int'(sb.setpoint) + int'(sb.regs.band) + 3;
        if (lo < 0) lo = 0;
        if (hi > 1023) hi = 1023;
        repeat ($urandom_range(6, 1)) begin
          if ($urandom_range(4) == 0) send_event(EV_TICK, 10'($urandom_range(1023)));
          send_event(EV_TEMP, 10'($urandom_range(hi, lo)));
        end
      end else if (pick < 70) begin
        // set-mode session: enter, step a few times, run to a timeout of at most 16
        if (sb.run_mode == RUN_ON)
          send_event($urandom_range(1) ? EV_UP : EV_DOWN, 10'($urandom_range(1023)));
        repeat ($urandom_range(4, 1)) begin
          if (sb.run_mode != RUN_SET) break;
          ticks = (sb.regs.timeout_seconds > 1) ?
                  $urandom_range(int'(sb.regs.timeout_seconds) - 1) : 0;
          if (ticks > 6) ticks = 6;
          repeat (ticks) send_event(EV_TICK, 10'($urandom_range(1023)));
          code = $urandom_range(1) ? EV_UP : EV_DOWN;
          send_event(code, 10'($urandom_range(1023)));
        end
        if (sb.regs.timeout_seconds <= 16) begin
          while (sb.run_mode == RUN_SET) send_event(EV_TICK, 10'($urandom_range(1023)));
        end
      end else if (pick < 80) begin
        // restore: favor the empty marker, with random upper bits
        if ($urandom_range(2) == 0)
          send_event(EV_RESTORE, {2'($urandom_range(3)), SP_EMPTY});
        else
          send_event(EV_RESTORE, 10'($urandom_range(1023)));
      end else if (pick < 88) begin
        send_event(EV_POWER, 10'($urandom_range(1023)));
      end else begin
        send_event(3'($urandom_range(7)), 10'($urandom_range(1023)));
      end
    end
  endtask

  initial begin
    cfg_t c;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phase 1: reset settings, slow-ish sender, very lazy receiver.
    send_idle_pct = 22;
    recv_idle_pct = 80;

    // Directed opening: off-mode presses, band edges, extreme values,
    // restore of the empty marker and of an unclamped byte, both clamps,
    // spare event codes, blink, timeout save and power-off from set mode.
    send_event(EV_TICK, 10'd0);
    send_event(EV_UP, 10'd0);               // ignored while off
    send_event(EV_POWER, 10'd0);            // on, cold: fan
    send_event(EV_TEMP, 10'h3ff);           // hottest: heater and hot flag
    send_event(EV_TEMP, 10'd60);            // inside band: hold
    send_event(EV_TEMP, 10'd55);            // lower edge
    send_event(EV_TEMP, 10'd65);            // upper edge
    send_event(EV_RESTORE, 10'h3ff);        // empty marker loads default
    send_event(EV_RESTORE, 10'h300);        // upper bits ignored, setpoint 0
    send_event(EV_RESTORE, 10'd200);        // out of limits, kept as is
    send_event(EV_UP, 10'd0);               // enter set mode
    send_event(EV_TICK, 10'd0);             // odd second: display dark
    send_event(EV_UP, 10'd0);               // clamp at high limit
    send_event(EV_DOWN, 10'd0);
    send_event(EV_RESTORE, 10'd30);         // below low limit
    send_event(EV_DOWN, 10'd0);             // clamp at low limit
    send_event(EV_SPARE6, 10'h155);
    send_event(EV_SPARE7, 10'h2aa);
    repeat (5) send_event(EV_TICK, 10'd0);  // last one saves and returns on
    send_event(EV_DOWN, 10'd0);
    send_event(EV_POWER, 10'd0);            // set straight to off
    send_event(EV_POWER, 10'd0);
    run_random(250);
    drain();

    // Phase 2: low limit 0, other registers at top value, roles of the two sides swapped.
    send_idle_pct = 80;
    recv_idle_pct = 22;
    c = '{low_limit: 8'd0, high_limit: 8'd255, step_size: 8'd255, band: 8'd255,
          timeout_seconds: 8'd255, default_setpoint: 8'd255};
    load_config(c);
    send_event(EV_RESTORE, 10'h0ff);
    send_event(EV_UP, 10'd0);
    send_event(EV_UP, 10'd0);
    send_event(EV_DOWN, 10'd0);
    run_random(250);
    drain();

    // Phase 3: bottom values but step size 1, inverted limits, zero timeout, no idling.
    // While traffic runs, hold the receiver off long enough to back up the input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    c = '{low_limit: 8'd255, high_limit: 8'd0, step_size: 8'd1, band: 8'd0,
          timeout_seconds: 8'd0, default_setpoint: 8'd0};
    load_config(c);
    fork
      run_random(125);
      begin
        repeat (30) @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join
    drain();

    // Phase 4: random everyday settings, still no idling.
    c.low_limit        = 8'($urandom_range(50, 20));
    c.high_limit       = 8'($urandom_range(100, 60));
    c.step_size        = 8'($urandom_range(10, 1));
    c.band             = 8'($urandom_range(10));
    c.timeout_seconds  = 8'($urandom_range(8, 1));
    c.default_setpoint = 8'($urandom_range(255));
    load_config(c);
    run_random(125);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d status beats from %0d events under %0d register settings plus reset",
             sb.statuses_checked, sb.events_seen, settings_run);
    $display("%0d timeout saves seen, one %0d-cycle receiver stall, %0d mismatches",
             sb.saves, HOLD_CYCLES, sb.errors);
    if (sb.errors == 0 && sb.status_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
